FILE: rtl/ste_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ste_pkg
// Shared types and constants for the shortest triangle edge block.
// ----------------------------------------------------------------------------
package ste_pkg;

  localparam int COORD_BITS = 24;
  localparam int DIFF_W     = COORD_BITS + 1;
  localparam int SQR_W      = 2 * DIFF_W;
  localparam int SUM_W      = SQR_W + 2;
  localparam int SQ_BITS    = 52;
  localparam int LEN_BITS   = SQ_BITS / 2;
  localparam int CMP_W      = (SUM_W > SQ_BITS) ? SUM_W : SQ_BITS;
  localparam int FE_STAGES  = 4;
  localparam int QDEPTH     = 4;
  localparam int QPTR_W     = $clog2(QDEPTH);
  localparam int QCNT_W     = $clog2(QDEPTH + 1);

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic [DIFF_W-1:0]            absd_t;
  typedef logic [SQR_W-1:0]             sqr_t;
  typedef logic [SQ_BITS-1:0]           sq_t;
  typedef logic [LEN_BITS-1:0]          len_t;
  typedef logic [QCNT_W-1:0]            qcnt_t;

  localparam sq_t SQ_MAX = '1;

  typedef struct packed {
    logic  empty;
    qcnt_t count;
  } q_stat_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_DONE
  } sqrt_state_t;

endpackage

FILE: rtl/ste_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ste_if
// Valid/ready channels: triangle input and edge result output.
// ----------------------------------------------------------------------------
interface ste_in_if;
  logic           valid;
  logic           ready;
  ste_pkg::coord_t a_x;
  ste_pkg::coord_t a_y;
  ste_pkg::coord_t a_z;
  ste_pkg::coord_t b_x;
  ste_pkg::coord_t b_y;
  ste_pkg::coord_t b_z;
  ste_pkg::coord_t c_x;
  ste_pkg::coord_t c_y;
  ste_pkg::coord_t c_z;
  logic           final_triangle;

  modport source (output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                  final_triangle, input ready);
  modport sink   (input valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                  final_triangle, output ready);
endinterface

interface ste_out_if;
  logic         valid;
  logic         ready;
  ste_pkg::len_t edge_length;
  ste_pkg::sq_t  edge_squared;

  modport source (output valid, edge_length, edge_squared, input ready);
  modport sink   (input valid, edge_length, edge_squared, output ready);
endinterface

FILE: rtl/ste_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ste_front
// Accepts triangles, forms squared edge lengths in a 4-stage pipeline and
// keeps the running minimum; pushes the mesh minimum on the final triangle.
// ----------------------------------------------------------------------------
module ste_front (
  input  logic             clk,
  input  logic             rst_n,
  ste_in_if.sink           in_ch,
  input  ste_pkg::q_stat_t q_stat,
  output logic             push,
  output ste_pkg::sq_t     push_data
);

  ste_pkg::coord_t pv [3][3];
  ste_pkg::coord_t qv [3][3];
  ste_pkg::absd_t  dif [3][3];

  ste_pkg::absd_t  ad_r  [3][3];
  ste_pkg::absd_t  ad_nxt[3][3];
  ste_pkg::sqr_t   sqr_r  [3][3];
  ste_pkg::sqr_t   sqr_nxt[3][3];
  ste_pkg::sq_t    esq_r  [3];
  ste_pkg::sq_t    esq_nxt[3];
  ste_pkg::sq_t    tmin_r;
  ste_pkg::sq_t    tmin_nxt;
  ste_pkg::sq_t    run_min_r;
  ste_pkg::sq_t    run_min_nxt;
  ste_pkg::sq_t    cand;

  logic [ste_pkg::FE_STAGES-1:0] vld_r;
  logic [ste_pkg::FE_STAGES-1:0] fin_r;
  logic [ste_pkg::QCNT_W:0]      pending;

  logic [ste_pkg::SUM_W-1:0] sum [3];
  logic [ste_pkg::CMP_W-1:0] sum_ext [3];
  ste_pkg::sq_t              m01;

  logic accept;

  // Edge pairs: AB, AC, BC
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      pv[0][k] = (k == 0) ? in_ch.a_x : (k == 1) ? in_ch.a_y : in_ch.a_z;
      qv[0][k] = (k == 0) ? in_ch.b_x : (k == 1) ? in_ch.b_y : in_ch.b_z;
      pv[1][k] = pv[0][k];
      qv[1][k] = (k == 0) ? in_ch.c_x : (k == 1) ? in_ch.c_y : in_ch.c_z;
      pv[2][k] = qv[0][k];
      qv[2][k] = qv[1][k];
    end
    for (int e = 0; e < 3; e++) begin
      for (int k = 0; k < 3; k++) begin
        dif[e][k] = {pv[e][k][ste_pkg::COORD_BITS-1], pv[e][k]}
                  - {qv[e][k][ste_pkg::COORD_BITS-1], qv[e][k]};
        ad_nxt[e][k]  = dif[e][k][ste_pkg::DIFF_W-1] ?
                        (ste_pkg::DIFF_W'(0) - dif[e][k]) : dif[e][k];
        sqr_nxt[e][k] = ste_pkg::SQR_W'(ad_r[e][k]) * ste_pkg::SQR_W'(ad_r[e][k]);
      end
      sum[e] = ste_pkg::SUM_W'(sqr_r[e][0]) + ste_pkg::SUM_W'(sqr_r[e][1])
             + ste_pkg::SUM_W'(sqr_r[e][2]);
      sum_ext[e] = ste_pkg::CMP_W'(sum[e]);
      // terms are nonnegative, so clamping the total matches per-step saturation
      esq_nxt[e] = (sum_ext[e] > ste_pkg::CMP_W'(ste_pkg::SQ_MAX)) ?
                   ste_pkg::SQ_MAX : sum_ext[e][ste_pkg::SQ_BITS-1:0];
    end
    m01      = (esq_r[1] < esq_r[0]) ? esq_r[1] : esq_r[0];
    tmin_nxt = (esq_r[2] < m01) ? esq_r[2] : m01;
  end

  // finals in flight reserve a queue slot each
  always_comb begin
    pending = (ste_pkg::QCNT_W + 1)'(q_stat.count);
    for (int s = 0; s < ste_pkg::FE_STAGES; s++) begin
      pending = pending + (ste_pkg::QCNT_W + 1)'(vld_r[s] & fin_r[s]);
    end
  end

  assign in_ch.ready = (pending < (ste_pkg::QCNT_W + 1)'(ste_pkg::QDEPTH));
  assign accept      = in_ch.valid & in_ch.ready;

  assign cand      = (tmin_r < run_min_r) ? tmin_r : run_min_r;
  assign push      = vld_r[ste_pkg::FE_STAGES-1] & fin_r[ste_pkg::FE_STAGES-1];
  assign push_data = cand;

  always_comb begin
    run_min_nxt = run_min_r;
    if (vld_r[ste_pkg::FE_STAGES-1]) begin
      run_min_nxt = fin_r[ste_pkg::FE_STAGES-1] ? ste_pkg::SQ_MAX : cand;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      fin_r     <= '0;
      run_min_r <= ste_pkg::SQ_MAX;
    end else begin
      vld_r     <= {vld_r[ste_pkg::FE_STAGES-2:0], accept};
      fin_r     <= {fin_r[ste_pkg::FE_STAGES-2:0], in_ch.final_triangle};
      run_min_r <= run_min_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ad_r   <= ad_nxt;
    sqr_r  <= sqr_nxt;
    esq_r  <= esq_nxt;
    tmin_r <= tmin_nxt;
  end

endmodule

FILE: rtl/ste_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ste_queue
// Small FIFO of mesh minima between the front pipeline and the root unit.
// ----------------------------------------------------------------------------
module ste_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  ste_pkg::sq_t     push_data,
  input  logic             pop,
  output ste_pkg::sq_t     head,
  output ste_pkg::q_stat_t q_stat
);

  ste_pkg::sq_t mem_r [ste_pkg::QDEPTH];

  logic [ste_pkg::QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [ste_pkg::QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  ste_pkg::qcnt_t             count_r, count_nxt;
  logic                       do_pop;

  assign do_pop = pop & (count_r != '0);

  always_comb begin
    wr_ptr_nxt = push   ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  assign head         = mem_r[rd_ptr_r];
  assign q_stat.empty = (count_r == '0);
  assign q_stat.count = count_r;

endmodule

FILE: rtl/ste_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ste_sqrt
// Bit-serial integer square root, one result bit per cycle, with the
// result held for the output channel.
// ----------------------------------------------------------------------------
module ste_sqrt (
  input  logic             clk,
  input  logic             rst_n,
  input  ste_pkg::q_stat_t q_stat,
  input  ste_pkg::sq_t     head,
  output logic             pop,
  ste_out_if.source        out_ch
);

  ste_pkg::sqrt_state_t state_r, state_nxt;

  ste_pkg::sq_t rem_r, rem_nxt;
  ste_pkg::sq_t res_r, res_nxt;
  ste_pkg::sq_t bit_r, bit_nxt;
  ste_pkg::sq_t sq_r,  sq_nxt;
  ste_pkg::sq_t trial;

  assign trial = res_r + bit_r;

  always_comb begin
    state_nxt = state_r;
    rem_nxt   = rem_r;
    res_nxt   = res_r;
    bit_nxt   = bit_r;
    sq_nxt    = sq_r;
    pop       = 1'b0;
    unique case (state_r)
      ste_pkg::ST_IDLE: begin
        if (!q_stat.empty) begin
          pop       = 1'b1;
          rem_nxt   = head;
          sq_nxt    = head;
          res_nxt   = '0;
          bit_nxt   = ste_pkg::sq_t'(1) << (ste_pkg::SQ_BITS - 2);
          state_nxt = ste_pkg::ST_CALC;
        end
      end
      ste_pkg::ST_CALC: begin
        if (rem_r >= trial) begin
          rem_nxt = rem_r - trial;
          res_nxt = (res_r >> 1) + bit_r;
        end else begin
          res_nxt = res_r >> 1;
        end
        bit_nxt = bit_r >> 2;
        if (bit_r[0]) begin
          state_nxt = ste_pkg::ST_DONE;
        end
      end
      ste_pkg::ST_DONE: begin
        if (out_ch.ready) begin
          state_nxt = ste_pkg::ST_IDLE;
        end
      end
      default: state_nxt = ste_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ste_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    res_r <= res_nxt;
    bit_r <= bit_nxt;
    sq_r  <= sq_nxt;
  end

  assign out_ch.valid        = (state_r == ste_pkg::ST_DONE);
  assign out_ch.edge_length  = res_r[ste_pkg::LEN_BITS-1:0];
  assign out_ch.edge_squared = sq_r;

endmodule

FILE: rtl/shortest_triangle_edge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shortest_triangle_edge
// Shortest edge of a triangle mesh streamed one triangle per item.
// ----------------------------------------------------------------------------
// Triangles are taken at one per cycle. A 4-stage front pipeline forms the
// three squared edge lengths (one multiplier per axis and edge) and folds
// them into a running minimum. On the item flagged final_triangle the mesh
// minimum goes into a 4-entry queue; a bit-serial square root loads it,
// forms the 26-bit root and holds it on the output channel until taken.
// Input stalls only while four mesh results are queued or in flight ahead
// of the root unit.
// ----------------------------------------------------------------------------
module shortest_triangle_edge (
  input  logic      clk,
  input  logic      rst_n,
  ste_in_if.sink    in_ch,
  ste_out_if.source out_ch
);

  ste_pkg::q_stat_t q_stat;
  ste_pkg::sq_t     push_data;
  ste_pkg::sq_t     head;
  logic             push;
  logic             pop;

  ste_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .q_stat    (q_stat),
    .push      (push),
    .push_data (push_data)
  );

  ste_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .q_stat    (q_stat)
  );

  ste_sqrt u_sqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_stat (q_stat),
    .head   (head),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule
